### rtl/core/rcad_pkg.sv
// Shared types, constants and register codes for the receiver arm/mode decoder.
`default_nettype none
package rcad_pkg;

  // Channel and pulse widths.
  localparam int RAW_W   = 11;
  localparam int PWM_W   = 12;
  localparam int HOLD_W  = 16;
  localparam int TOL_W   = 10;
  localparam int LANES   = 5;

  // Scaling ranges.
  localparam int RAW_MIN   = 172;
  localparam int RAW_MAX   = 1811;
  localparam int PULSE_MIN = 1000;
  localparam int PULSE_MAX = 2000;

  // Derived scaling constants. An empty raw range maps every channel to PULSE_MIN.
  localparam bit RAW_EMPTY  = (RAW_MAX <= RAW_MIN);
  localparam int RAW_SPAN   = RAW_EMPTY ? 1 : (RAW_MAX - RAW_MIN);
  localparam int PULSE_SPAN = PULSE_MAX - PULSE_MIN;
  localparam bit PULSE_NEG  = (PULSE_SPAN < 0);
  localparam int PULSE_MAG  = PULSE_NEG ? -PULSE_SPAN : PULSE_SPAN;

  // Product of the offset and the pulse span stays below 2^23.
  localparam int PROD_W      = RAW_W + PWM_W;
  localparam int RECIP_SHIFT = PROD_W + 1;
  localparam int RECIP_W     = RECIP_SHIFT + 1;
  localparam int RECIP       = (1 << RECIP_SHIFT) / RAW_SPAN;
  localparam int QM_W        = PROD_W + RECIP_W;

  // Configuration address bits.
  localparam int ADDR_W = 5;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_LINK     = 2'd1,
    STATUS_FAILSAFE = 2'd2,
    STATUS_FRAME    = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    MODE_LOW  = 2'd0,
    MODE_MID  = 2'd1,
    MODE_HIGH = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    REG_STICK_TOL   = 3'd0,
    REG_ARM_HOLD    = 3'd1,
    REG_DISARM_HOLD = 3'd2,
    REG_MODE_LOW    = 3'd3,
    REG_MODE_HIGH   = 3'd4,
    REG_SWITCH_MID  = 3'd5,
    REG_ARM_SW_EN   = 3'd6,
    REG_KILL_SW_EN  = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic             link_lost;
    logic             failsafe_flag;
    logic             frame_dropped;
    logic [RAW_W-1:0] throttle_raw;
    logic [RAW_W-1:0] yaw_raw;
    logic [RAW_W-1:0] mode_raw;
    logic [RAW_W-1:0] arm_switch_raw;
    logic [RAW_W-1:0] kill_switch_raw;
  } in_word_t;

  typedef struct packed {
    logic [1:0]       status_code;
    logic             armed;
    logic [1:0]       flight_mode;
    logic             kill_active;
    logic [PWM_W-1:0] throttle_pwm;
    logic [PWM_W-1:0] yaw_pwm;
  } out_word_t;

  typedef struct packed {
    logic [TOL_W-1:0]  stick_tolerance;
    logic [HOLD_W-1:0] arm_hold_count;
    logic [HOLD_W-1:0] disarm_hold_count;
    logic [PWM_W-1:0]  mode_low_threshold;
    logic [PWM_W-1:0]  mode_high_threshold;
    logic [PWM_W-1:0]  switch_midpoint;
    logic              arm_switch_enable;
    logic              kill_switch_enable;
  } cfg_t;

  // Stage load strobes shared by all scaling lanes.
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } lane_load_t;

endpackage
`default_nettype wire

### rtl/core/rcad_scale_lane.sv
// One channel scaling lane: clamp, multiply by the pulse span, divide by the raw span.
`default_nettype none
module rcad_scale_lane (
  input  wire logic                      clk,
  input  wire rcad_pkg::lane_load_t      load,
  input  wire logic [rcad_pkg::RAW_W-1:0] raw,
  output logic [rcad_pkg::PWM_W-1:0]     pwm
);

  localparam int PW = rcad_pkg::PROD_W;
  localparam int QW = rcad_pkg::PWM_W;

  logic [rcad_pkg::RAW_W-1:0] clamped;
  logic [rcad_pkg::RAW_W-1:0] offset;
  logic [PW-1:0]              prod_next;
  logic [PW-1:0]              prod1;
  logic [rcad_pkg::QM_W-1:0]  qm;
  logic [QW-1:0]              qest_next;
  logic [QW-1:0]              qest2;
  logic [PW-1:0]              prod2;
  logic [PW-1:0]              qd;
  logic [PW-1:0]              rem;
  logic [QW:0]                quot;
  logic signed [QW+2:0]       val;
  logic [QW-1:0]              pwm_next;

  // Stage one: saturate to the raw range and multiply by the pulse span magnitude.
  always_comb begin
    clamped = raw;
    if (raw < rcad_pkg::RAW_W'(rcad_pkg::RAW_MIN)) begin
      clamped = rcad_pkg::RAW_W'(rcad_pkg::RAW_MIN);
    end
    if (raw > rcad_pkg::RAW_W'(rcad_pkg::RAW_MAX)) begin
      clamped = rcad_pkg::RAW_W'(rcad_pkg::RAW_MAX);
    end
    offset    = clamped - rcad_pkg::RAW_W'(rcad_pkg::RAW_MIN);
    prod_next = PW'(offset) * PW'(rcad_pkg::PULSE_MAG);
  end

  always_ff @(posedge clk) begin
    if (load.s1) begin
      prod1 <= prod_next;
    end
  end

  // Stage two: quotient estimate by the reciprocal of the raw span.
  always_comb begin
    qm        = rcad_pkg::QM_W'(prod1) * rcad_pkg::QM_W'(rcad_pkg::RECIP);
    qest_next = QW'(qm >> rcad_pkg::RECIP_SHIFT);
  end

  always_ff @(posedge clk) begin
    if (load.s2) begin
      qest2 <= qest_next;
      prod2 <= prod1;
    end
  end

  // Stage three: correct the estimate by one, apply the sign, offset and clamp.
  always_comb begin
    qd   = PW'(qest2) * PW'(rcad_pkg::RAW_SPAN);
    rem  = prod2 - qd;
    quot = {1'b0, qest2} + (QW+1)'(rem >= PW'(rcad_pkg::RAW_SPAN));
    if (rcad_pkg::PULSE_NEG) begin
      val = -$signed({2'b00, quot});
    end else begin
      val = $signed({2'b00, quot});
    end
    val = val + (QW+3)'(rcad_pkg::PULSE_MIN);
    if (rcad_pkg::RAW_EMPTY) begin
      val = (QW+3)'(rcad_pkg::PULSE_MIN);
    end
    if (val < 0) begin
      pwm_next = '0;
    end else if (val > (QW+3)'(4095)) begin
      pwm_next = '1;
    end else begin
      pwm_next = val[QW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (load.s3) begin
      pwm <= pwm_next;
    end
  end

endmodule
`default_nettype wire

### rtl/core/rcad_decide.sv
// Merging stage: stick gestures, arm switch gating, mode thresholds and kill latch.
`default_nettype none
module rcad_decide (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       load,
  input  wire rcad_pkg::status_t          status,
  input  wire logic [rcad_pkg::PWM_W-1:0] thr,
  input  wire logic [rcad_pkg::PWM_W-1:0] yaw,
  input  wire logic [rcad_pkg::PWM_W-1:0] mode,
  input  wire logic [rcad_pkg::PWM_W-1:0] arm_sw,
  input  wire logic [rcad_pkg::PWM_W-1:0] kill_sw,
  input  wire rcad_pkg::cfg_t             cfg,
  output rcad_pkg::out_word_t             result
);

  localparam int HW = rcad_pkg::HOLD_W;
  localparam int SW = rcad_pkg::PWM_W + 3;

  logic                       armed_state, armed_state_next;
  logic [HW-1:0]              arm_hold, arm_hold_next;
  logic [HW-1:0]              disarm_hold, disarm_hold_next;
  rcad_pkg::mode_t            mode_state, mode_state_next;
  logic                       kill_state, kill_state_next;
  logic [rcad_pkg::PWM_W-1:0] last_thr, last_thr_next;
  logic [rcad_pkg::PWM_W-1:0] last_yaw, last_yaw_next;
  logic signed [SW-1:0]       low_end, high_end, thr_s, yaw_s;
  logic                       arm_sw_on;

  // Next state from one good frame; an error frame leaves everything as it is.
  always_comb begin
    armed_state_next = armed_state;
    arm_hold_next    = arm_hold;
    disarm_hold_next = disarm_hold;
    mode_state_next  = mode_state;
    kill_state_next  = kill_state;
    last_thr_next    = last_thr;
    last_yaw_next    = last_yaw;

    low_end   = SW'(rcad_pkg::PULSE_MIN) + $signed(SW'(cfg.stick_tolerance));
    high_end  = SW'(rcad_pkg::PULSE_MAX) - $signed(SW'(cfg.stick_tolerance));
    thr_s     = $signed(SW'(thr));
    yaw_s     = $signed(SW'(yaw));
    arm_sw_on = arm_sw > cfg.switch_midpoint;

    if (status == rcad_pkg::STATUS_OK) begin
      if (thr_s <= low_end) begin
        // Disarm gesture: yaw held at its low end.
        if (yaw_s <= low_end) begin
          disarm_hold_next = (disarm_hold == '1) ? disarm_hold : disarm_hold + 1'b1;
          if (disarm_hold_next >= cfg.disarm_hold_count) begin
            armed_state_next = 1'b0;
          end
        end else begin
          disarm_hold_next = '0;
        end
        // Arm gesture: yaw held at its high end; applied last so it wins.
        if (yaw_s >= high_end) begin
          arm_hold_next = (arm_hold == '1) ? arm_hold : arm_hold + 1'b1;
          if (arm_hold_next >= cfg.arm_hold_count) begin
            armed_state_next = cfg.arm_switch_enable ? arm_sw_on : 1'b1;
          end
        end else begin
          arm_hold_next = '0;
        end
      end else begin
        disarm_hold_next = '0;
        arm_hold_next    = '0;
      end

      if (mode < cfg.mode_low_threshold) begin
        mode_state_next = rcad_pkg::MODE_LOW;
      end else if (mode < cfg.mode_high_threshold) begin
        mode_state_next = rcad_pkg::MODE_MID;
      end else begin
        mode_state_next = rcad_pkg::MODE_HIGH;
      end

      if (cfg.kill_switch_enable) begin
        kill_state_next = kill_sw > cfg.switch_midpoint;
      end

      last_thr_next = thr;
      last_yaw_next = yaw;
    end
  end

  // Held state, updated as each frame moves into the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      armed_state <= 1'b0;
      arm_hold    <= '0;
      disarm_hold <= '0;
      mode_state  <= rcad_pkg::MODE_LOW;
      kill_state  <= 1'b0;
      last_thr    <= '0;
      last_yaw    <= '0;
    end else if (load) begin
      armed_state <= armed_state_next;
      arm_hold    <= arm_hold_next;
      disarm_hold <= disarm_hold_next;
      mode_state  <= mode_state_next;
      kill_state  <= kill_state_next;
      last_thr    <= last_thr_next;
      last_yaw    <= last_yaw_next;
    end
  end

  // Result word register.
  always_ff @(posedge clk) begin
    if (load) begin
      result.status_code  <= status;
      result.armed        <= armed_state_next;
      result.flight_mode  <= mode_state_next;
      result.kill_active  <= kill_state_next;
      result.throttle_pwm <= last_thr_next;
      result.yaw_pwm      <= last_yaw_next;
    end
  end

endmodule
`default_nettype wire

### rtl/core/rc_arm_disarm_mode_decoder_unit.sv
// Top level of the receiver arm/disarm and flight mode decoder.
//
//   channel   | signals                                | direction
//   ----------+----------------------------------------+----------
//   frame     | frame_valid, frame_stall, frame        | in
//   result    | result_valid, result_stall, result     | out
//   config    | psel, penable, pwrite, paddr, pwdata,  | in / out
//             | prdata, pready                         |
//
// One frame is accepted every cycle unless frame_stall is raised. The first scaling
// stage loads at the accepting edge; the word then passes two more scaling stages in
// the five parallel lanes and the merging register, which holds the result word.
// Reset is synchronous and clears the held arm, mode and kill state and the
// pipeline valid bits. A stalled result holds in its register while earlier
// stages keep filling; frame_stall rises only when every stage is occupied.
`default_nettype none
module rc_arm_disarm_mode_decoder_unit (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         frame_valid,
  output logic                              frame_stall,
  input  wire rcad_pkg::in_word_t           frame,
  output logic                              result_valid,
  input  wire logic                         result_stall,
  output rcad_pkg::out_word_t               result,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [rcad_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [31:0]                  pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  rcad_pkg::cfg_t       cfg;
  rcad_pkg::reg_idx_t   reg_idx;
  rcad_pkg::lane_load_t lane_load;
  rcad_pkg::status_t    status_in, status1, status2, status3;
  logic                 v1, v2, v3;
  logic                 out_free, s3_free, s2_free, s1_free;
  logic                 adv1, adv2, adv3, frame_take;
  logic [rcad_pkg::RAW_W-1:0] lane_raw [rcad_pkg::LANES];
  logic [rcad_pkg::PWM_W-1:0] lane_pwm [rcad_pkg::LANES];

  // Configuration registers.
  assign pready  = 1'b1;
  assign reg_idx = rcad_pkg::reg_idx_t'(paddr[rcad_pkg::ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.stick_tolerance     <= 10'd50;
      cfg.arm_hold_count      <= 16'd100;
      cfg.disarm_hold_count   <= 16'd100;
      cfg.mode_low_threshold  <= 12'd1300;
      cfg.mode_high_threshold <= 12'd1700;
      cfg.switch_midpoint     <= 12'd1500;
      cfg.arm_switch_enable   <= 1'b1;
      cfg.kill_switch_enable  <= 1'b1;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_idx)
        rcad_pkg::REG_STICK_TOL:   cfg.stick_tolerance     <= pwdata[9:0];
        rcad_pkg::REG_ARM_HOLD:    cfg.arm_hold_count      <= pwdata[15:0];
        rcad_pkg::REG_DISARM_HOLD: cfg.disarm_hold_count   <= pwdata[15:0];
        rcad_pkg::REG_MODE_LOW:    cfg.mode_low_threshold  <= pwdata[11:0];
        rcad_pkg::REG_MODE_HIGH:   cfg.mode_high_threshold <= pwdata[11:0];
        rcad_pkg::REG_SWITCH_MID:  cfg.switch_midpoint     <= pwdata[11:0];
        rcad_pkg::REG_ARM_SW_EN:   cfg.arm_switch_enable   <= pwdata[0];
        rcad_pkg::REG_KILL_SW_EN:  cfg.kill_switch_enable  <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Register read back.
  always_comb begin
    case (reg_idx)
      rcad_pkg::REG_STICK_TOL:   prdata = 32'(cfg.stick_tolerance);
      rcad_pkg::REG_ARM_HOLD:    prdata = 32'(cfg.arm_hold_count);
      rcad_pkg::REG_DISARM_HOLD: prdata = 32'(cfg.disarm_hold_count);
      rcad_pkg::REG_MODE_LOW:    prdata = 32'(cfg.mode_low_threshold);
      rcad_pkg::REG_MODE_HIGH:   prdata = 32'(cfg.mode_high_threshold);
      rcad_pkg::REG_SWITCH_MID:  prdata = 32'(cfg.switch_midpoint);
      rcad_pkg::REG_ARM_SW_EN:   prdata = 32'(cfg.arm_switch_enable);
      rcad_pkg::REG_KILL_SW_EN:  prdata = 32'(cfg.kill_switch_enable);
      default:                   prdata = '0;
    endcase
  end

  // Pipeline flow: a stage moves on when the next one is empty or moving.
  always_comb begin
    out_free   = !result_valid || !result_stall;
    adv3       = v3 && out_free;
    s3_free    = !v3 || out_free;
    adv2       = v2 && s3_free;
    s2_free    = !v2 || s3_free;
    adv1       = v1 && s2_free;
    s1_free    = !v1 || s2_free;
    frame_take = frame_valid && s1_free;
    frame_stall = !s1_free;
    lane_load.s1 = frame_take;
    lane_load.s2 = adv1;
    lane_load.s3 = adv2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1           <= 1'b0;
      v2           <= 1'b0;
      v3           <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      v1           <= frame_take || (v1 && !s2_free);
      v2           <= adv1 || (v2 && !s3_free);
      v3           <= adv2 || (v3 && !out_free);
      result_valid <= adv3 || (result_valid && result_stall);
    end
  end

  // Error flags in priority order travel beside the lanes.
  always_comb begin
    if (frame.link_lost) begin
      status_in = rcad_pkg::STATUS_LINK;
    end else if (frame.failsafe_flag) begin
      status_in = rcad_pkg::STATUS_FAILSAFE;
    end else if (frame.frame_dropped) begin
      status_in = rcad_pkg::STATUS_FRAME;
    end else begin
      status_in = rcad_pkg::STATUS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (frame_take) begin
      status1 <= status_in;
    end
    if (adv1) begin
      status2 <= status1;
    end
    if (adv2) begin
      status3 <= status2;
    end
  end

  // Five scaling lanes, one per channel.
  assign lane_raw[0] = frame.throttle_raw;
  assign lane_raw[1] = frame.yaw_raw;
  assign lane_raw[2] = frame.mode_raw;
  assign lane_raw[3] = frame.arm_switch_raw;
  assign lane_raw[4] = frame.kill_switch_raw;

  for (genvar i = 0; i < rcad_pkg::LANES; i++) begin : g_lane
    rcad_scale_lane u_lane (
      .clk  (clk),
      .load (lane_load),
      .raw  (lane_raw[i]),
      .pwm  (lane_pwm[i])
    );
  end

  // Merge the lanes into the held state and the result word.
  rcad_decide u_decide (
    .clk     (clk),
    .rst     (rst),
    .load    (adv3),
    .status  (status3),
    .thr     (lane_pwm[0]),
    .yaw     (lane_pwm[1]),
    .mode    (lane_pwm[2]),
    .arm_sw  (lane_pwm[3]),
    .kill_sw (lane_pwm[4]),
    .cfg     (cfg),
    .result  (result)
  );

endmodule
`default_nettype wire

### tb/rc_arm_disarm_mode_decoder_unit_tb.sv
// Self-checking testbench for the receiver arm/disarm and flight mode decoder.
`timescale 1ns / 100ps
module rc_arm_disarm_mode_decoder_unit_tb;
  import rcad_pkg::*;

  localparam int LIMIT_CYCLES = 1000000;
  localparam int DRAIN_CYCLES = 12;
  localparam int RESET_CYCLES = 12;
  localparam int PHASE_ITEMS  = 608;
  localparam int HOLD_MAX     = 65535;
  localparam int HOLD_RUN     = 40;

  // Raw value zones used to build stick gestures.
  localparam int ZONE_LOW  = 0;
  localparam int ZONE_HIGH = 1;
  localparam int ZONE_ANY  = 2;

  logic clk = 1'b0;
  logic rst;
  logic frame_valid;
  logic frame_stall;
  in_word_t frame_word;
  logic result_valid;
  logic result_stall;
  out_word_t result_word;
  logic psel;
  logic penable;
  logic pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  int send_idle_pct = 8;
  int recv_idle_pct = 53;
  int mismatch_count = 0;
  int cycle_count = 0;

  // Decoded words still owed by the block, oldest first.
  out_word_t decoded_words_q[$];
  out_word_t want_word;

  // Shadow of the configuration registers.
  logic [TOL_W-1:0]  tol_cfg = 10'd50;
  logic [HOLD_W-1:0] arm_hold_cfg = 16'd100;
  logic [HOLD_W-1:0] disarm_hold_cfg = 16'd100;
  logic [PWM_W-1:0]  mode_low_cfg = 12'd1300;
  logic [PWM_W-1:0]  mode_high_cfg = 12'd1700;
  logic [PWM_W-1:0]  switch_mid_cfg = 12'd1500;
  logic              arm_sw_en_cfg = 1'b1;
  logic              kill_sw_en_cfg = 1'b1;

  // Shadow of the decoder state.
  logic              armed_q = 1'b0;
  logic [HOLD_W-1:0] arm_hold_q = '0;
  logic [HOLD_W-1:0] disarm_hold_q = '0;
  mode_t             mode_q = MODE_LOW;
  logic              kill_q = 1'b0;
  logic [PWM_W-1:0]  thr_pwm_q = '0;
  logic [PWM_W-1:0]  yaw_pwm_q = '0;

  rc_arm_disarm_mode_decoder_unit i_dut (
    .clk          (clk),
    .rst          (rst),
    .frame_valid  (frame_valid),
    .frame_stall  (frame_stall),
    .frame        (frame_word),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result_word),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #2 clk = ~clk;

  // Linear raw-to-pulse mapping with input saturation and output clamp.
  function automatic int stick_pulse(logic [RAW_W-1:0] raw);
    longint x;
    longint r;
    x = longint'(raw);
    if (RAW_MAX <= RAW_MIN) begin
      r = PULSE_MIN;
    end else begin
      if (x < RAW_MIN) x = RAW_MIN;
      if (x > RAW_MAX) x = RAW_MAX;
      r = ((x - RAW_MIN) * (longint'(PULSE_MAX) - PULSE_MIN)) /
          (longint'(RAW_MAX) - RAW_MIN) + PULSE_MIN;
    end
    if (r < 0) r = 0;
    if (r > 4095) r = 4095;
    return int'(r);
  endfunction

  // Advances the shadow state by one frame and returns the word it produces.
  function automatic out_word_t decode_frame(in_word_t f);
    out_word_t o;
    status_t st;
    int thr, yaw, md, asw, ksw, low_end, high_end;
    st = STATUS_OK;
    if (f.link_lost) st = STATUS_LINK;
    else if (f.failsafe_flag) st = STATUS_FAILSAFE;
    else if (f.frame_dropped) st = STATUS_FRAME;
    if (st == STATUS_OK) begin
      thr = stick_pulse(f.throttle_raw);
      yaw = stick_pulse(f.yaw_raw);
      md  = stick_pulse(f.mode_raw);
      asw = stick_pulse(f.arm_switch_raw);
      ksw = stick_pulse(f.kill_switch_raw);
      low_end  = PULSE_MIN + int'(tol_cfg);
      high_end = PULSE_MAX - int'(tol_cfg);
      // Disarm rule first, arm rule second, so arming wins when both hold.
      if (thr <= low_end) begin
        if (yaw <= low_end) begin
          if (disarm_hold_q != 16'hFFFF) disarm_hold_q = disarm_hold_q + 16'd1;
          if (disarm_hold_q >= disarm_hold_cfg) armed_q = 1'b0;
        end else begin
          disarm_hold_q = '0;
        end
        if (yaw >= high_end) begin
          if (arm_hold_q != 16'hFFFF) arm_hold_q = arm_hold_q + 16'd1;
          if (arm_hold_q >= arm_hold_cfg) begin
            if (arm_sw_en_cfg) armed_q = (asw > int'(switch_mid_cfg));
            else armed_q = 1'b1;
          end
        end else begin
          arm_hold_q = '0;
        end
      end else begin
        disarm_hold_q = '0;
        arm_hold_q = '0;
      end
      if (md < int'(mode_low_cfg)) mode_q = MODE_LOW;
      else if (md < int'(mode_high_cfg)) mode_q = MODE_MID;
      else mode_q = MODE_HIGH;
      if (kill_sw_en_cfg) kill_q = (ksw > int'(switch_mid_cfg));
      thr_pwm_q = PWM_W'(thr);
      yaw_pwm_q = PWM_W'(yaw);
    end
    o.status_code  = st;
    o.armed        = armed_q;
    o.flight_mode  = mode_q;
    o.kill_active  = kill_q;
    o.throttle_pwm = thr_pwm_q;
    o.yaw_pwm      = yaw_pwm_q;
    return o;
  endfunction

  function automatic in_word_t build_frame(logic [2:0] flags, int thr, int yaw, int md,
                                           int asw, int ksw);
    in_word_t w;
    {w.link_lost, w.failsafe_flag, w.frame_dropped} = flags;
    w.throttle_raw    = RAW_W'(thr);
    w.yaw_raw         = RAW_W'(yaw);
    w.mode_raw        = RAW_W'(md);
    w.arm_switch_raw  = RAW_W'(asw);
    w.kill_switch_raw = RAW_W'(ksw);
    return w;
  endfunction

  function automatic int pick_raw(int zone);
    case (zone)
      ZONE_LOW:  return $urandom_range(0, 450);
      ZONE_HIGH: return $urandom_range(1550, 2047);
      default:   return $urandom_range(0, 2047);
    endcase
  endfunction

  // Random frame following one gesture kind, with an occasional error flag.
  function automatic in_word_t random_frame(int kind);
    logic [2:0] flags;
    int thr, yaw, asw;
    flags = ($urandom_range(99) < 8) ? 3'($urandom_range(1, 7)) : 3'b000;
    case (kind)
      0, 1, 2, 3: begin
        thr = pick_raw(ZONE_LOW);
        yaw = pick_raw(ZONE_HIGH);
        asw = ($urandom_range(99) < 70) ? pick_raw(ZONE_HIGH) : pick_raw(ZONE_ANY);
      end
      4, 5, 6: begin
        thr = pick_raw(ZONE_LOW);
        yaw = pick_raw(ZONE_LOW);
        asw = pick_raw(ZONE_ANY);
      end
      7: begin
        thr = pick_raw(ZONE_HIGH);
        yaw = pick_raw(ZONE_ANY);
        asw = pick_raw(ZONE_ANY);
      end
      default: begin
        thr = pick_raw(ZONE_ANY);
        yaw = pick_raw(ZONE_ANY);
        asw = pick_raw(ZONE_ANY);
      end
    endcase
    return build_frame(flags, thr, yaw, pick_raw(ZONE_ANY), asw, pick_raw(ZONE_ANY));
  endfunction

  // Offers one word, waits for it to be taken, and records its decoded word.
  task automatic send_frame(in_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      frame_valid <= 1'b0;
      @(posedge clk);
    end
    frame_valid <= 1'b1;
    frame_word  <= w;
    @(posedge clk);
    while (frame_stall) @(posedge clk);
    decoded_words_q.push_back(decode_frame(w));
  endtask

  // Stops sending and waits until every decoded word has come back.
  task automatic wait_drain();
    frame_valid <= 1'b0;
    @(posedge clk);
    while (decoded_words_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // One register write: setup cycle, access cycle, then release of the bus.
  task automatic write_reg(reg_idx_t idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(int'(idx) * 4);
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_STICK_TOL:   tol_cfg = value[TOL_W-1:0];
      REG_ARM_HOLD:    arm_hold_cfg = value[HOLD_W-1:0];
      REG_DISARM_HOLD: disarm_hold_cfg = value[HOLD_W-1:0];
      REG_MODE_LOW:    mode_low_cfg = value[PWM_W-1:0];
      REG_MODE_HIGH:   mode_high_cfg = value[PWM_W-1:0];
      REG_SWITCH_MID:  switch_mid_cfg = value[PWM_W-1:0];
      REG_ARM_SW_EN:   arm_sw_en_cfg = value[0];
      REG_KILL_SW_EN:  kill_sw_en_cfg = value[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Picks a value in [lo, hi], sometimes an end point, sometimes with junk above the field.
  function automatic logic [31:0] pick_setting(int lo, int hi, int typ_lo, int typ_hi,
                                               int width);
    logic [31:0] v;
    logic [31:0] mask;
    case ($urandom_range(0, 9))
      0:       v = lo;
      1:       v = hi;
      default: v = $urandom_range(typ_lo, typ_hi);
    endcase
    mask = (32'd1 << width) - 32'd1;
    if ($urandom_range(99) < 30) v = v | ($urandom & ~mask);
    return v;
  endfunction

  task automatic write_random_settings();
    write_reg(REG_STICK_TOL, pick_setting(0, 1000, 0, 300, TOL_W));
    write_reg(REG_ARM_HOLD, pick_setting(0, HOLD_MAX, 0, 12, HOLD_W));
    write_reg(REG_DISARM_HOLD, pick_setting(0, HOLD_MAX, 0, 12, HOLD_W));
    write_reg(REG_MODE_LOW, pick_setting(0, 4095, 900, 2100, PWM_W));
    write_reg(REG_MODE_HIGH, pick_setting(0, 4095, 900, 2100, PWM_W));
    write_reg(REG_SWITCH_MID, pick_setting(0, 4095, 900, 2100, PWM_W));
    write_reg(REG_ARM_SW_EN, pick_setting(0, 1, 0, 1, 1));
    write_reg(REG_KILL_SW_EN, pick_setting(0, 1, 0, 1, 1));
  endtask

  // Error frames right after reset: every flag mix, extreme channel values.
  task automatic test_error_frames();
    for (int m = 1; m < 8; m++) begin
      if (m % 2 == 1) send_frame(build_frame(3'(m), 2047, 2047, 2047, 2047, 2047));
      else send_frame(build_frame(3'(m), 0, 0, 0, 0, 0));
    end
  endtask

  // Saturation at both ends of the raw range and the mode thresholds.
  task automatic test_scaling_edges();
    send_frame(build_frame(3'b000, 0, 0, 0, 0, 0));
    send_frame(build_frame(3'b000, 2047, 2047, 2047, 2047, 2047));
    send_frame(build_frame(3'b000, 171, 1812, 171, 1812, 171));
    send_frame(build_frame(3'b000, 172, 1811, 1811, 172, 1811));
    send_frame(build_frame(3'b000, 1000, 500, 1300, 1600, 2047));
    send_frame(build_frame(3'b000, 1811, 172, 1000, 900, 2047));
    // A flagged frame must hold the last good pulse widths.
    send_frame(build_frame(3'b100, 0, 0, 0, 0, 0));
  endtask

  // Gesture priority, arm switch gating, held kill flag, crossed thresholds.
  task automatic test_gesture_rules();
    wait_drain();
    write_reg(REG_STICK_TOL, 32'd1000);
    write_reg(REG_ARM_HOLD, 32'd1);
    write_reg(REG_DISARM_HOLD, 32'd1);
    write_reg(REG_ARM_SW_EN, 32'd1);
    // Both gestures hold at once; the arm rule decides.
    send_frame(build_frame(3'b000, 1000, 1000, 1000, 2047, 0));
    // Arm switch off with the hold complete forces a disarm.
    send_frame(build_frame(3'b000, 1000, 1000, 1000, 0, 0));
    wait_drain();
    write_reg(REG_ARM_SW_EN, 32'd0);
    send_frame(build_frame(3'b000, 1000, 1000, 1000, 0, 2047));
    wait_drain();
    write_reg(REG_STICK_TOL, 32'd0);
    write_reg(REG_DISARM_HOLD, 32'd0);
    write_reg(REG_KILL_SW_EN, 32'd0);
    write_reg(REG_MODE_LOW, 32'd1800);
    write_reg(REG_MODE_HIGH, 32'd1200);
    // Disarm gesture, kill switch ignored, crossed mode thresholds.
    send_frame(build_frame(3'b000, 172, 172, 172, 2047, 0));
    send_frame(build_frame(3'b000, 172, 1811, 1500, 2047, 0));
    send_frame(build_frame(3'b000, 172, 1811, 1300, 0, 2047));
  endtask

  // Hold counters run up to and past their programmed counts with back-to-back words.
  task automatic test_hold_counts();
    wait_drain();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(REG_STICK_TOL, 32'd50);
    write_reg(REG_ARM_HOLD, HOLD_RUN);
    write_reg(REG_DISARM_HOLD, HOLD_RUN);
    write_reg(REG_ARM_SW_EN, 32'd1);
    write_reg(REG_KILL_SW_EN, 32'd1);
    for (int k = 0; k < HOLD_RUN + 8; k++)
      send_frame(build_frame(3'b000, 172, 2047, 0, 2047, 0));
    // With the hold complete the arm switch keeps steering the armed state.
    for (int k = 0; k < 12; k++)
      send_frame(build_frame(3'b000, 172, 2047, 0, (k % 2 == 0) ? 0 : 2047, 0));
    for (int k = 0; k < HOLD_RUN + 8; k++) send_frame(build_frame(3'b000, 0, 0, 0, 0, 0));
  endtask

  // Gesture runs with random content; settings change at the start and mid-way.
  task automatic test_random_phase(int sender_pct, int receiver_pct);
    int sent;
    int run_len;
    int kind;
    int hold_top;
    int pause_at;
    wait_drain();
    send_idle_pct = sender_pct;
    recv_idle_pct = receiver_pct;
    write_random_settings();
    pause_at = $urandom_range(PHASE_ITEMS / 4, 3 * PHASE_ITEMS / 4);
    sent = 0;
    while (sent < PHASE_ITEMS) begin
      kind = $urandom_range(0, 9);
      hold_top = (arm_hold_cfg > disarm_hold_cfg) ? int'(arm_hold_cfg) : int'(disarm_hold_cfg);
      if (hold_top > 26) hold_top = 26;
      run_len = $urandom_range(1, hold_top + 4);
      for (int k = 0; k < run_len && sent < PHASE_ITEMS; k++) begin
        send_frame(random_frame(kind));
        sent++;
        if (sent == pause_at) begin
          wait_drain();
          write_random_settings();
        end
      end
    end
  endtask

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // Receiver: random stall, and every accepted word checked against the oldest prediction.
  always @(posedge clk) begin
    result_stall <= ($urandom_range(99) < recv_idle_pct);
    if (!rst && result_valid && !result_stall) begin
      if (decoded_words_q.size() == 0) begin
        $display("%0t: unexpected result word, actual %p", $time, result_word);
        mismatch_count++;
      end else begin
        want_word = decoded_words_q.pop_front();
        check_field("status_code", want_word.status_code, result_word.status_code);
        check_field("armed", want_word.armed, result_word.armed);
        check_field("flight_mode", want_word.flight_mode, result_word.flight_mode);
        check_field("kill_active", want_word.kill_active, result_word.kill_active);
        check_field("throttle_pwm", want_word.throttle_pwm, result_word.throttle_pwm);
        check_field("yaw_pwm", want_word.yaw_pwm, result_word.yaw_pwm);
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("rc_arm_disarm_mode_decoder_unit_tb: FAIL");
      $finish;
    end
  end

  initial begin
    rst          <= 1'b1;
    frame_valid  <= 1'b0;
    frame_word   <= '0;
    result_stall <= 1'b0;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_error_frames();
    test_scaling_edges();
    test_gesture_rules();
    test_random_phase(8, 53);
    test_random_phase(53, 8);
    test_hold_counts();
    test_random_phase(0, 0);
    wait_drain();

    if (mismatch_count == 0 && decoded_words_q.size() == 0) begin
      $display("rc_arm_disarm_mode_decoder_unit_tb: PASS");
    end else begin
      $display("rc_arm_disarm_mode_decoder_unit_tb: FAIL");
    end
    $finish;
  end

endmodule

### sim.f
rtl/core/rcad_pkg.sv
rtl/core/rcad_scale_lane.sv
rtl/core/rcad_decide.sv
rtl/core/rc_arm_disarm_mode_decoder_unit.sv
tb/rc_arm_disarm_mode_decoder_unit_tb.sv
